// ----- rtl/core/thermal_feedforward_tuner_stepper_macros.svh -----
// Assertion helpers shared by the tuner stepper RTL.
`ifndef THERMAL_FEEDFORWARD_TUNER_STEPPER_MACROS_SVH
`define THERMAL_FEEDFORWARD_TUNER_STEPPER_MACROS_SVH

// same-cycle implication, clocked on aclk, off while in reset
`define TFTS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TFTS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/tfts_pkg.sv -----
`timescale 1ns / 1ps

package tfts_pkg;

    // stream payload layout
    localparam int S_DATA_W   = 24;
    localparam int M_DATA_W   = 56;
    localparam int IN_ADC_W   = 10;
    localparam int OUT_POS_W  = 16;
    localparam int OUT_TGT_W  = 32;

    localparam int S_PULSE_B  = 0;
    localparam int S_SERVO_B  = 1;
    localparam int S_HEAT_LO  = 2;
    localparam int S_REFL_LO  = 12;
    localparam int S_TICK_B   = 22;

    localparam int M_DIR_LO   = 0;
    localparam int M_POS_LO   = 2;
    localparam int M_TGT_LO   = 18;

    // configuration port
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 3;

    localparam logic [REG_IDX_W-1:0] REG_HOME       = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_COOL_SHIFT = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_COOL_RATE  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_PRE_SHIFT  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_DRIFT_GAIN = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_POST_SHIFT = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_DEADBAND   = 3'd6;

    // step command codes
    localparam logic [1:0] DIR_STOP = 2'd0;
    localparam logic [1:0] DIR_FWD  = 2'd1;
    localparam logic [1:0] DIR_REV  = 2'd2;

    // arithmetic widths
    localparam int MUL_W    = 16;
    localparam int DRIFT_W  = 41;
    localparam int SUM_W    = 43;
    localparam int DIFF_W   = 34;

    // microcode
    localparam int STEP_W = 4;
    localparam int OP_W   = 4;
    localparam int COND_W = 3;

    localparam logic [STEP_W-1:0] ST_FETCH   = 4'd0;
    localparam logic [STEP_W-1:0] ST_PULSE   = 4'd1;
    localparam logic [STEP_W-1:0] ST_LDCOOL  = 4'd2;
    localparam logic [STEP_W-1:0] ST_MULCOOL = 4'd3;
    localparam logic [STEP_W-1:0] ST_COOL    = 4'd4;
    localparam logic [STEP_W-1:0] ST_LDDRIFT = 4'd5;
    localparam logic [STEP_W-1:0] ST_MULDRFT = 4'd6;
    localparam logic [STEP_W-1:0] ST_DRIFT   = 4'd7;
    localparam logic [STEP_W-1:0] ST_TARGET  = 4'd8;
    localparam logic [STEP_W-1:0] ST_MOVE    = 4'd9;
    localparam logic [STEP_W-1:0] ST_WRAP    = 4'd10;

    localparam logic [OP_W-1:0] OP_NOP     = 4'd0;
    localparam logic [OP_W-1:0] OP_FETCH   = 4'd1;
    localparam logic [OP_W-1:0] OP_PULSE   = 4'd2;
    localparam logic [OP_W-1:0] OP_LDCOOL  = 4'd3;
    localparam logic [OP_W-1:0] OP_MUL     = 4'd4;
    localparam logic [OP_W-1:0] OP_COOL    = 4'd5;
    localparam logic [OP_W-1:0] OP_LDDRIFT = 4'd6;
    localparam logic [OP_W-1:0] OP_DRIFT   = 4'd7;
    localparam logic [OP_W-1:0] OP_TARGET  = 4'd8;
    localparam logic [OP_W-1:0] OP_MOVE    = 4'd9;

    localparam logic [COND_W-1:0] C_NEXT     = 3'd0;
    localparam logic [COND_W-1:0] C_ALWAYS   = 3'd1;
    localparam logic [COND_W-1:0] C_NO_INPUT = 3'd2;
    localparam logic [COND_W-1:0] C_NO_TICK  = 3'd3;
    localparam logic [COND_W-1:0] C_MUL_MORE = 3'd4;
    localparam logic [COND_W-1:0] C_OUT_BUSY = 3'd5;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [COND_W-1:0] cond;
        logic [STEP_W-1:0] tgt;
    } uword_t;

    // control store: jump to tgt when cond holds, else fall through
    function automatic uword_t ucode(input logic [STEP_W-1:0] addr);
        uword_t w;
        w = '{op: OP_NOP, cond: C_ALWAYS, tgt: ST_FETCH};
        unique case (addr)
            ST_FETCH:   w = '{op: OP_FETCH,   cond: C_NO_INPUT, tgt: ST_FETCH};
            ST_PULSE:   w = '{op: OP_PULSE,   cond: C_NEXT,     tgt: ST_FETCH};
            ST_LDCOOL:  w = '{op: OP_LDCOOL,  cond: C_NO_TICK,  tgt: ST_LDDRIFT};
            ST_MULCOOL: w = '{op: OP_MUL,     cond: C_MUL_MORE, tgt: ST_MULCOOL};
            ST_COOL:    w = '{op: OP_COOL,    cond: C_NEXT,     tgt: ST_FETCH};
            ST_LDDRIFT: w = '{op: OP_LDDRIFT, cond: C_NEXT,     tgt: ST_FETCH};
            ST_MULDRFT: w = '{op: OP_MUL,     cond: C_MUL_MORE, tgt: ST_MULDRFT};
            ST_DRIFT:   w = '{op: OP_DRIFT,   cond: C_NEXT,     tgt: ST_FETCH};
            ST_TARGET:  w = '{op: OP_TARGET,  cond: C_NEXT,     tgt: ST_FETCH};
            ST_MOVE:    w = '{op: OP_MOVE,    cond: C_OUT_BUSY, tgt: ST_MOVE};
            ST_WRAP:    w = '{op: OP_NOP,     cond: C_ALWAYS,   tgt: ST_FETCH};
            default:    w = '{op: OP_NOP,     cond: C_ALWAYS,   tgt: ST_FETCH};
        endcase
        return w;
    endfunction

endpackage

// ----- rtl/core/thermal_feedforward_tuner_stepper.sv -----
// Thermal feed-forward tuner stepper.
// Input stream (s_*): one item per control iteration carrying the pulse and
// servo flags, heat and reflected converter samples and the cooling tick.
// Output stream (m_*): one item per input item: step command, motor position
// after the step and the computed target position.
// APB port: seven configuration registers at byte addresses 0, 4, .. 24;
// write them only while no item is in flight.
// An item makes N = ceil(ACC_WIDTH / 16) passes of the shared 16x16
// multiplier, N more when cool_tick is set (N = 2 at the default width).
// The microcode sequencer works on one item at a time; s_tready is high
// only at its fetch step.
// The result sits in an output register: if the receiver stalls, the next
// item is still accepted and worked on, and the sequencer waits at its move
// step until the register is free.
// Reset clears the accumulator, position, last reflected sample and pulse
// error and loads the register defaults; no result is pending after reset.
`timescale 1ns / 1ps

module thermal_feedforward_tuner_stepper #(
    parameter int ACC_WIDTH = 32,
    parameter int ADC_BITS  = 10,
    parameter int POS_WIDTH = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // tdata: pulse_seen, servo_on, heat_sample[9:0], reflected_sample[9:0],
    //        cool_tick, pad
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [tfts_pkg::S_DATA_W-1:0]       s_tdata,
    // tdata: step_dir[1:0], motor_position[15:0], target_position[31:0], pad
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [tfts_pkg::M_DATA_W-1:0]       m_tdata,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [tfts_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [tfts_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [tfts_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    import tfts_pkg::*;

    localparam int NCHUNK = (ACC_WIDTH + MUL_W - 1) / MUL_W;
    localparam int CW     = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam int OPA_W  = NCHUNK * MUL_W;
    localparam int PROD_W = OPA_W + MUL_W;
    localparam int WIDE_W = (PROD_W > DRIFT_W) ? PROD_W : DRIFT_W;
    localparam int ERR_W  = ADC_BITS + 1;

    localparam logic [ACC_WIDTH-1:0] ACC_MAX   = {ACC_WIDTH{1'b1}};
    localparam logic [POS_WIDTH-1:0] POS_MAX   = {POS_WIDTH{1'b1}};
    localparam logic [WIDE_W-1:0]    DRIFT_CAP = WIDE_W'(1) << (DRIFT_W - 1);
    localparam logic signed [SUM_W-1:0] TGT_HI = SUM_W'(32'sh7FFF_FFFF);
    localparam logic signed [SUM_W-1:0] TGT_LO = -(SUM_W'(33'sh0_8000_0000));

    // configuration
    logic [15:0]         home_reg;
    logic [4:0]          cool_shift_reg;
    logic [7:0]          cool_rate_reg;
    logic [4:0]          pre_shift_reg;
    logic [15:0]         drift_gain_reg;
    logic [4:0]          post_shift_reg;
    logic [9:0]          deadband_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                cfg_wr;

    // sequencer
    logic [STEP_W-1:0]   upc_reg;
    logic [STEP_W-1:0]   upc_next;
    uword_t              uw;
    logic                cond_hit;
    logic                s_accept;
    logic                out_busy;

    // captured item
    logic                in_pulse_reg;
    logic                in_servo_reg;
    logic                in_tick_reg;
    logic [ADC_BITS-1:0] in_heat_reg;
    logic [ADC_BITS-1:0] in_refl_reg;

    // state
    logic [ACC_WIDTH-1:0]    acc_reg;
    logic [POS_WIDTH-1:0]    pos_reg;
    logic [ADC_BITS-1:0]     last_refl_reg;
    logic signed [ERR_W-1:0] perr_reg;

    // datapath
    logic [OPA_W-1:0]        opa_reg;
    logic [MUL_W-1:0]        mulb_reg;
    logic [PROD_W-1:0]       prod_reg;
    logic [CW-1:0]           chunk_reg;
    logic [DRIFT_W-1:0]      drift_reg;
    logic signed [OUT_TGT_W-1:0] target_reg;

    logic [MUL_W-1:0]        opa_chunk;
    logic [2*MUL_W-1:0]      mul_part;
    logic [ACC_WIDTH:0]      acc_sum;
    logic [WIDE_W-1:0]       drift_wide;
    logic signed [SUM_W-1:0] tgt_sum;
    logic signed [DIFF_W-1:0] pos_diff;
    logic signed [DIFF_W-1:0] db_s;

    // output register
    logic                    m_tvalid_reg;
    logic [1:0]              out_dir_reg;
    logic [OUT_POS_W-1:0]    out_pos_reg;
    logic [OUT_TGT_W-1:0]    out_tgt_reg;

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            home_reg       <= 16'd0;
            cool_shift_reg <= 5'd10;
            cool_rate_reg  <= 8'd1;
            pre_shift_reg  <= 5'd8;
            drift_gain_reg <= 16'd1;
            post_shift_reg <= 5'd0;
            deadband_reg   <= 10'd2;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_HOME:       home_reg       <= pwdata[15:0];
                REG_COOL_SHIFT: cool_shift_reg <= pwdata[4:0];
                REG_COOL_RATE:  cool_rate_reg  <= pwdata[7:0];
                REG_PRE_SHIFT:  pre_shift_reg  <= pwdata[4:0];
                REG_DRIFT_GAIN: drift_gain_reg <= pwdata[15:0];
                REG_POST_SHIFT: post_shift_reg <= pwdata[4:0];
                REG_DEADBAND:   deadband_reg   <= pwdata[9:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_HOME:       prdata = APB_DATA_W'(home_reg);
            REG_COOL_SHIFT: prdata = APB_DATA_W'(cool_shift_reg);
            REG_COOL_RATE:  prdata = APB_DATA_W'(cool_rate_reg);
            REG_PRE_SHIFT:  prdata = APB_DATA_W'(pre_shift_reg);
            REG_DRIFT_GAIN: prdata = APB_DATA_W'(drift_gain_reg);
            REG_POST_SHIFT: prdata = APB_DATA_W'(post_shift_reg);
            REG_DEADBAND:   prdata = APB_DATA_W'(deadband_reg);
            default:        prdata = '0;
        endcase
    end

    // ---------------- sequencer ----------------
    assign uw       = ucode(upc_reg);
    assign s_tready = (upc_reg == ST_FETCH);
    assign s_accept = s_tvalid && s_tready;
    assign out_busy = m_tvalid_reg && !m_tready;

    always_comb begin
        unique case (uw.cond)
            C_NEXT:     cond_hit = 1'b0;
            C_ALWAYS:   cond_hit = 1'b1;
            C_NO_INPUT: cond_hit = !s_tvalid;
            C_NO_TICK:  cond_hit = !in_tick_reg;
            C_MUL_MORE: cond_hit = (chunk_reg != CW'(NCHUNK - 1));
            C_OUT_BUSY: cond_hit = out_busy;
            default:    cond_hit = 1'b1;
        endcase
        upc_next = cond_hit ? uw.tgt : upc_reg + STEP_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= ST_FETCH;
        end else begin
            upc_reg <= upc_next;
        end
    end

    // ---------------- datapath ----------------
    assign opa_chunk = opa_reg[chunk_reg*MUL_W +: MUL_W];
    assign mul_part  = opa_chunk * mulb_reg;
    assign acc_sum   = {1'b0, acc_reg} + (ACC_WIDTH+1)'(in_heat_reg);
    assign drift_wide = WIDE_W'(prod_reg) >> post_shift_reg;
    assign tgt_sum   = $signed(SUM_W'(drift_reg)) + $signed(SUM_W'(home_reg))
                       + SUM_W'(perr_reg);
    assign pos_diff  = $signed(DIFF_W'(pos_reg)) - DIFF_W'(target_reg);
    assign db_s      = $signed(DIFF_W'(deadband_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg       <= '0;
            pos_reg       <= '0;
            last_refl_reg <= '0;
            perr_reg      <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            // the move step reloads the output register itself
            if (m_tready && uw.op != OP_MOVE) begin
                m_tvalid_reg <= 1'b0;
            end
            case (uw.op)
                OP_FETCH: begin
                    if (s_accept) begin
                        in_pulse_reg <= s_tdata[S_PULSE_B];
                        in_servo_reg <= s_tdata[S_SERVO_B];
                        in_tick_reg  <= s_tdata[S_TICK_B];
                        in_heat_reg  <= ADC_BITS'(s_tdata[S_HEAT_LO +: IN_ADC_W]);
                        in_refl_reg  <= ADC_BITS'(s_tdata[S_REFL_LO +: IN_ADC_W]);
                    end
                end
                OP_PULSE: begin
                    if (in_pulse_reg) begin
                        if (in_servo_reg) begin
                            acc_reg <= acc_sum[ACC_WIDTH] ? ACC_MAX
                                                          : acc_sum[ACC_WIDTH-1:0];
                            perr_reg <= $signed({1'b0, in_refl_reg})
                                        - $signed({1'b0, last_refl_reg});
                            last_refl_reg <= in_refl_reg;
                        end else begin
                            perr_reg <= '0;
                        end
                    end
                end
                OP_LDCOOL: begin
                    opa_reg   <= OPA_W'(acc_reg >> cool_shift_reg);
                    mulb_reg  <= MUL_W'(cool_rate_reg);
                    prod_reg  <= '0;
                    chunk_reg <= '0;
                end
                OP_LDDRIFT: begin
                    opa_reg   <= OPA_W'(acc_reg >> pre_shift_reg);
                    mulb_reg  <= drift_gain_reg;
                    prod_reg  <= '0;
                    chunk_reg <= '0;
                end
                OP_MUL: begin
                    prod_reg  <= prod_reg + (PROD_W'(mul_part) << (chunk_reg * MUL_W));
                    chunk_reg <= chunk_reg + CW'(1);
                end
                OP_COOL: begin
                    // drop floors the accumulator at zero
                    if (prod_reg >= PROD_W'(acc_reg)) begin
                        acc_reg <= '0;
                    end else begin
                        acc_reg <= acc_reg - ACC_WIDTH'(prod_reg);
                    end
                end
                OP_DRIFT: begin
                    drift_reg <= (drift_wide > DRIFT_CAP) ? DRIFT_W'(DRIFT_CAP)
                                                          : DRIFT_W'(drift_wide);
                end
                OP_TARGET: begin
                    if (tgt_sum > TGT_HI) begin
                        target_reg <= OUT_TGT_W'(TGT_HI);
                    end else if (tgt_sum < TGT_LO) begin
                        target_reg <= OUT_TGT_W'(TGT_LO);
                    end else begin
                        target_reg <= OUT_TGT_W'(tgt_sum);
                    end
                end
                OP_MOVE: begin
                    if (!out_busy) begin
                        m_tvalid_reg <= 1'b1;
                        out_tgt_reg  <= target_reg;
                        if (pos_diff < -db_s && pos_reg < POS_MAX) begin
                            pos_reg     <= pos_reg + POS_WIDTH'(1);
                            out_pos_reg <= OUT_POS_W'(pos_reg + POS_WIDTH'(1));
                            out_dir_reg <= DIR_FWD;
                        end else if (pos_diff > db_s && pos_reg != '0) begin
                            pos_reg     <= pos_reg - POS_WIDTH'(1);
                            out_pos_reg <= OUT_POS_W'(pos_reg - POS_WIDTH'(1));
                            out_dir_reg <= DIR_REV;
                        end else begin
                            // inside the deadband or held at a limit
                            out_pos_reg <= OUT_POS_W'(pos_reg);
                            out_dir_reg <= DIR_STOP;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_DATA_W - M_TGT_LO - OUT_TGT_W){1'b0}},
                       out_tgt_reg, out_pos_reg, out_dir_reg};

    // ---------------- assertions ----------------
`include "thermal_feedforward_tuner_stepper_macros.svh"

    `TFTS_ASSERT_NEXT(a_accept_starts_pulse, s_accept, upc_reg == ST_PULSE, "item accepted but pulse step not next")
    `TFTS_ASSERT_NEXT(a_pos_one_count, 1'b1, (pos_reg == $past(pos_reg)) || (pos_reg == $past(pos_reg) + POS_WIDTH'(1)) || (pos_reg == $past(pos_reg) - POS_WIDTH'(1)), "motor moved more than one count")
    `TFTS_ASSERT_SAME(a_result_from_move, $rose(m_tvalid_reg), $past(upc_reg) == ST_MOVE, "result raised outside move step")

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import tfts_pkg::*;

    localparam int     HOLD_CYCLES = 300;
    localparam int     SETTLE      = 20;
    localparam int     CYCLE_LIMIT = 400000;
    localparam int     SIDE_TX     = 0;
    localparam int     SIDE_RX     = 1;
    localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam longint unsigned ACC_TOP   = 64'hFFFF_FFFF;
    localparam longint unsigned DRIFT_CAP = 64'd1 << 40;
    localparam longint TGT_HI = 64'sd2147483647;
    localparam longint TGT_LO = -64'sd2147483648;
    localparam logic [OUT_POS_W-1:0] POS_TOP = '1;

    typedef struct packed {
        logic [1:0]           dir;
        logic [OUT_POS_W-1:0] pos;
        logic [OUT_TGT_W-1:0] tgt;
    } step_res_t;

    typedef struct {
        logic [S_DATA_W-1:0] data;
        bit                  pinned;
        step_res_t           res;
    } bench_row_t;

    typedef struct {
        bit        pinned;
        step_res_t res;
    } pin_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // register copies and tuner state as the predictor sees them
    logic [31:0]          cfg_val [0:6];
    longint unsigned      heat_acc;
    logic [OUT_POS_W-1:0] motor_pos;
    logic [IN_ADC_W-1:0]  last_refl;
    longint               pulse_err;

    step_res_t  expected_steps [$];
    pin_t       pinned_steps [$];
    bench_row_t bench_rows [$];

    int  items_sent;
    int  steps_seen;
    int  mismatches;
    int  cycle_count;
    bit  hold_req;
    bit  calm_mode [0:1];
    int  calm_left [0:1];
    logic [IN_ADC_W-1:0] near_refl;

    thermal_feedforward_tuner_stepper i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic logic [S_DATA_W-1:0] pack_item(input logic pulse, input logic servo,
                                                      input logic [IN_ADC_W-1:0] heat,
                                                      input logic [IN_ADC_W-1:0] refl,
                                                      input logic tick);
        logic [S_DATA_W-1:0] d;
        d = '0;
        d[S_PULSE_B] = pulse;
        d[S_SERVO_B] = servo;
        d[S_HEAT_LO +: IN_ADC_W] = heat;
        d[S_REFL_LO +: IN_ADC_W] = refl;
        d[S_TICK_B] = tick;
        return d;
    endfunction

    // one control iteration: pulse, cooling, target, then at most one step
    function automatic step_res_t tuner_iterate(input logic [S_DATA_W-1:0] d);
        logic                pulse;
        logic                servo;
        logic                tick;
        logic [IN_ADC_W-1:0] heat;
        logic [IN_ADC_W-1:0] refl;
        longint unsigned     drop;
        longint unsigned     drift;
        longint              tgt;
        longint              diff;
        longint              db;
        step_res_t           r;
        pulse = d[S_PULSE_B];
        servo = d[S_SERVO_B];
        tick  = d[S_TICK_B];
        heat  = d[S_HEAT_LO +: IN_ADC_W];
        refl  = d[S_REFL_LO +: IN_ADC_W];
        if (pulse) begin
            pulse_err = 0;
            if (servo) begin
                heat_acc = heat_acc + heat;
                if (heat_acc > ACC_TOP)
                    heat_acc = ACC_TOP;
                pulse_err = longint'(refl) - longint'(last_refl);
                last_refl = refl;
            end
        end
        if (tick) begin
            drop = (heat_acc >> cfg_val[REG_COOL_SHIFT]) * cfg_val[REG_COOL_RATE];
            heat_acc = (drop >= heat_acc) ? 64'd0 : heat_acc - drop;
        end
        // 32-bit accumulator times 16-bit gain stays below 2^48, no wrap
        drift = ((heat_acc >> cfg_val[REG_PRE_SHIFT]) * cfg_val[REG_DRIFT_GAIN])
                >> cfg_val[REG_POST_SHIFT];
        if (drift > DRIFT_CAP)
            drift = DRIFT_CAP;
        tgt = longint'(cfg_val[REG_HOME]) + longint'(drift) + pulse_err;
        if (tgt > TGT_HI)
            tgt = TGT_HI;
        if (tgt < TGT_LO)
            tgt = TGT_LO;
        diff = longint'(motor_pos) - tgt;
        db = longint'(cfg_val[REG_DEADBAND]);
        r.dir = DIR_STOP;
        if (diff < -db) begin
            if (motor_pos != POS_TOP) begin
                motor_pos = motor_pos + 1'b1;
                r.dir = DIR_FWD;
            end
        end else if (diff > db) begin
            if (motor_pos != '0) begin
                motor_pos = motor_pos - 1'b1;
                r.dir = DIR_REV;
            end
        end
        r.pos = motor_pos;
        r.tgt = tgt[31:0];
        return r;
    endfunction

    // random mix: mostly servo pulses with reflected power wandering slowly
    function automatic logic [S_DATA_W-1:0] random_item();
        logic                pulse;
        logic                servo;
        logic                tick;
        logic [IN_ADC_W-1:0] heat;
        logic [IN_ADC_W-1:0] refl;
        pulse = ($urandom_range(0, 9) < 7);
        servo = ($urandom_range(0, 9) < 8);
        tick  = ($urandom_range(0, 3) == 0);
        case ($urandom_range(0, 7))
            0: heat = '0;
            1: heat = '1;
            default: heat = IN_ADC_W'($urandom_range(0, 1023));
        endcase
        if ($urandom_range(0, 4) == 0)
            refl = IN_ADC_W'($urandom);
        else
            refl = IN_ADC_W'(near_refl + $urandom_range(0, 15) - 8);
        if (pulse && servo)
            near_refl = refl;
        return pack_item(pulse, servo, heat, refl, tick);
    endfunction

    function automatic int idle_cycles(input int side);
        if (calm_left[side] == 0) begin
            calm_mode[side] = ($urandom_range(0, 3) == 0);
            calm_left[side] = $urandom_range(10, 60);
        end
        calm_left[side] = calm_left[side] - 1;
        return calm_mode[side] ? 0 : $urandom_range(0, 13);
    endfunction

    task automatic flag_mismatch(input string msg);
        mismatches = mismatches + 1;
        if (mismatches <= 10)
            $display("MISMATCH: %s", msg);
    endtask

    task automatic send_item(input logic [S_DATA_W-1:0] d);
        int gap;
        gap = idle_cycles(SIDE_TX);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        do @(posedge aclk); while (!s_tready);
        items_sent = items_sent + 1;
    endtask

    task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [31:0] val);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx != REG_UNUSED)
            cfg_val[idx] = val;
    endtask

    task automatic apb_read_check(input logic [REG_IDX_W-1:0] idx);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata !== cfg_val[idx])
            flag_mismatch($sformatf("register %0d: expected %0d, got %0d",
                                    idx, cfg_val[idx], prdata));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // stop offering the last item so it is not taken twice
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        wait (steps_seen >= items_sent);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic apply_setting(input logic [31:0] home, input logic [31:0] cshift,
                                 input logic [31:0] crate, input logic [31:0] pre,
                                 input logic [31:0] gain, input logic [31:0] post,
                                 input logic [31:0] dband);
        logic [31:0] vals [0:6];
        vals = '{home, cshift, crate, pre, gain, post, dband};
        wait_idle();
        // write to the hole in the map first: must not disturb anything
        apb_write(REG_UNUSED, $urandom);
        for (int i = 0; i < 7; i++) begin
            apb_write(i[REG_IDX_W-1:0], vals[i]);
            apb_read_check(i[REG_IDX_W-1:0]);
        end
    endtask

    task automatic run_random(input int n, input bit with_hold);
        for (int i = 0; i < n; i++) begin
            if (with_hold && i == 40)
                hold_req = 1'b1;
            send_item(random_item());
        end
    endtask

    task automatic add_row(input logic pulse, input logic servo, input logic [9:0] heat,
                           input logic [9:0] refl, input logic tick, input bit pinned,
                           input logic [1:0] dir, input logic [15:0] pos,
                           input logic [31:0] tgt);
        bench_row_t row;
        row.data    = pack_item(pulse, servo, heat, refl, tick);
        row.pinned  = pinned;
        row.res.dir = dir;
        row.res.pos = pos;
        row.res.tgt = tgt;
        bench_rows.push_back(row);
    endtask

    // accepted input item: run the predictor, or use a typed-in result
    always @(posedge aclk) begin : accept_mon
        step_res_t r;
        pin_t      p;
        if (aresetn && s_tvalid && s_tready) begin
            r = tuner_iterate(s_tdata);
            if (pinned_steps.size() > 0) begin
                p = pinned_steps.pop_front();
                if (p.pinned)
                    r = p.res;
            end
            expected_steps.push_back(r);
        end
    end

    always @(posedge aclk) begin : result_mon
        step_res_t e;
        logic [1:0]  got_dir;
        logic [15:0] got_pos;
        logic [31:0] got_tgt;
        if (aresetn && m_tvalid && m_tready) begin
            got_dir = m_tdata[M_DIR_LO +: 2];
            got_pos = m_tdata[M_POS_LO +: OUT_POS_W];
            got_tgt = m_tdata[M_TGT_LO +: OUT_TGT_W];
            if (expected_steps.size() == 0) begin
                flag_mismatch($sformatf("unexpected result item dir %0d pos %0d tgt %0d",
                                        got_dir, got_pos, $signed(got_tgt)));
            end else begin
                e = expected_steps.pop_front();
                if (got_dir !== e.dir)
                    flag_mismatch($sformatf("item %0d step_dir: expected %0d, got %0d",
                                            steps_seen, e.dir, got_dir));
                if (got_pos !== e.pos)
                    flag_mismatch($sformatf("item %0d motor_position: expected %0d, got %0d",
                                            steps_seen, e.pos, got_pos));
                if (got_tgt !== e.tgt)
                    flag_mismatch($sformatf("item %0d target_position: expected %0d, got %0d",
                                            steps_seen, $signed(e.tgt), $signed(got_tgt)));
            end
            steps_seen = steps_seen + 1;
        end
    end

    // receiver: random back-pressure, plus one long hold-off on request
    initial begin : receiver
        int gap;
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                gap = HOLD_CYCLES;
            end else begin
                gap = idle_cycles(SIDE_RX);
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    initial begin : main
        cycle_count = 0;
        items_sent  = 0;
        steps_seen  = 0;
        mismatches  = 0;
        hold_req    = 1'b0;
        near_refl   = '0;
        calm_mode   = '{1'b0, 1'b0};
        calm_left   = '{0, 0};
        cfg_val     = '{32'd0, 32'd10, 32'd1, 32'd8, 32'd1, 32'd0, 32'd2};
        heat_acc    = 0;
        motor_pos   = '0;
        last_refl   = '0;
        pulse_err   = 0;

        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < 7; i++)
            apb_read_check(i[REG_IDX_W-1:0]);

        // defaults: home 0, drift = acc >> 8, deadband 2
        add_row(1'b0, 1'b0, 10'd0, 10'd0, 1'b0, 1'b1, DIR_STOP, 16'd0, 32'd0);
        add_row(1'b1, 1'b1, 10'd1023, 10'd1023, 1'b0, 1'b1, DIR_FWD, 16'd1, 32'd1026);
        add_row(1'b1, 1'b1, 10'd0, 10'd0, 1'b0, 1'b1, DIR_REV, 16'd0, -32'sd1020);
        // no pulse holds the error; already at zero so no reverse step
        add_row(1'b0, 1'b0, 10'd0, 10'd0, 1'b0, 1'b1, DIR_STOP, 16'd0, -32'sd1020);
        // pulse with servo off clears the error
        add_row(1'b1, 1'b0, 10'd512, 10'd700, 1'b0, 1'b1, DIR_FWD, 16'd1, 32'd3);
        add_row(1'b0, 1'b0, 10'd0, 10'd0, 1'b1, 1'b0, DIR_STOP, 16'd0, 32'd0);
        add_row(1'b1, 1'b1, 10'd1023, 10'd1, 1'b1, 1'b0, DIR_STOP, 16'd0, 32'd0);
        add_row(1'b1, 1'b1, 10'd0, 10'd1023, 1'b0, 1'b0, DIR_STOP, 16'd0, 32'd0);
        add_row(1'b0, 1'b1, 10'd1023, 10'd1023, 1'b0, 1'b0, DIR_STOP, 16'd0, 32'd0);
        add_row(1'b0, 1'b1, 10'd0, 10'd0, 1'b1, 1'b0, DIR_STOP, 16'd0, 32'd0);
        add_row(1'b1, 1'b1, 10'd1023, 10'd1023, 1'b1, 1'b0, DIR_STOP, 16'd0, 32'd0);
        add_row(1'b1, 1'b1, 10'd1023, 10'd1022, 1'b0, 1'b0, DIR_STOP, 16'd0, 32'd0);
        add_row(1'b1, 1'b1, 10'd341, 10'd682, 1'b1, 1'b0, DIR_STOP, 16'd0, 32'd0);
        add_row(1'b0, 1'b0, 10'd0, 10'd0, 1'b0, 1'b0, DIR_STOP, 16'd0, 32'd0);
        foreach (bench_rows[i]) begin
            pinned_steps.push_back('{bench_rows[i].pinned, bench_rows[i].res});
            send_item(bench_rows[i].data);
        end

        apply_setting(300, 10, 1, 8, 1, 0, 2);
        run_random(262, 1'b0);
        // shift 0 with max rate empties the accumulator on every tick
        apply_setting(0, 0, 255, 0, 65535, 31, 0);
        run_random(262, 1'b1);
        apply_setting(65535, 31, 0, 31, 0, 0, 1023);
        run_random(262, 1'b0);
        // no cooling and full gain: target pins at the top of the signed range
        apply_setting(500, 31, 255, 0, 65535, 0, 5);
        run_random(262, 1'b0);
        apply_setting(1000, 6, 17, 2, 300, 12, 7);
        run_random(262, 1'b0);
        for (int k = 0; k < 2; k++) begin
            apply_setting($urandom_range(0, 2000), $urandom_range(0, 31),
                          $urandom_range(0, 255), $urandom_range(0, 31),
                          $urandom_range(0, 65535), $urandom_range(0, 31),
                          $urandom_range(0, 1023));
            run_random(262, 1'b0);
        end

        wait_idle();
        if (expected_steps.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", expected_steps.size()));
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
